// ===== rtl/core/wlt_pkg.sv =====
package wlt_pkg;

    localparam int LOAD_W   = 20;
    localparam int GAIN_W   = 20;
    localparam int SPRING_W = 22;
    localparam int CFG_W    = 22;
    localparam int IDX_W    = 3;
    localparam int QUAT_W   = 16;
    localparam int ACC_W    = 18;
    localparam int CORNERS  = 4;

    localparam logic [LOAD_W-1:0] LOAD_MAX   = 20'hFFFFF;
    localparam logic [15:0]       COMP_SCALE = 16'd62500;

    // Register map
    typedef enum logic [IDX_W-1:0] {
        REG_STATIC_LOAD = 3'd0,
        REG_LONG_GAIN   = 3'd1,
        REG_LAT_GAIN    = 3'd2,
        REG_SPRING_RATE = 3'd3,
        REG_MAX_TRAVEL  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [LOAD_W-1:0]   static_load;
        logic [GAIN_W-1:0]   long_gain;
        logic [GAIN_W-1:0]   lat_gain;
        logic [SPRING_W-1:0] spring_rate;
        logic [LOAD_W-1:0]   max_travel;
    } t_cfg;

    // Corner order: front left, front right, rear left, rear right
    typedef logic [LOAD_W-1:0]        t_load;
    typedef t_load [CORNERS-1:0]      t_corners;

    // Queue status between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/wlt_front.sv =====
module wlt_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wlt_pkg::t_cfg                     i_cfg,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_w,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_x,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_y,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_z,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_x,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_y,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_z,
    input  wlt_pkg::t_q_status                i_q_status,
    output logic                              o_push,
    output wlt_pkg::t_corners                 o_loads
);
    import wlt_pkg::*;

    localparam logic signed [33:0] ONE_Q28 = 34'sh1000_0000;

    function automatic t_load clamp_load(input logic signed [37:0] v);
        t_load res;
        if (v < 0) begin
            res = '0;
        end else if (v > 38'(LOAD_MAX)) begin
            res = LOAD_MAX;
        end else begin
            res = v[LOAD_W-1:0];
        end
        return res;
    endfunction

    logic en;
    logic [5:0] r_v;

    // stage 1: quaternion products
    logic signed [31:0] r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [ACC_W-1:0] r_ax1, r_ay1, r_az1;
    // stage 2: matrix rows in Q28
    logic signed [33:0] r_m00, r_m01, r_m02, r_m20, r_m21, r_m22;
    logic signed [ACC_W-1:0] r_ax2, r_ay2, r_az2;
    // stage 3: matrix times acceleration
    logic signed [51:0] r_p00, r_p01, r_p02, r_p20, r_p21, r_p22;
    // stage 4: local frame components
    logic signed [25:0] r_lx, r_lz;
    // stage 5: transfers
    logic signed [35:0] r_dlong, r_dlat;
    // stage 6: corner loads
    t_corners r_loads;

    logic signed [33:0] s_yz_sum, s_xy_sum;
    logic signed [53:0] s_sum_x, s_sum_z;
    logic signed [26:0] s_fwd, s_right;
    logic signed [47:0] s_long_p, s_lat_p;
    logic signed [37:0] s_st, s_dl, s_dt;

    // advance unless the last stage waits on a full queue
    assign en      = !(r_v[5] && i_q_status.full);
    assign o_stall = !en;
    assign o_push  = r_v[5] && !i_q_status.full;
    assign o_loads = r_loads;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_comb begin
        s_yz_sum = 34'(r_yy) + 34'(r_zz);
        s_xy_sum = 34'(r_xx) + 34'(r_yy);
        s_sum_x  = 54'(r_p00) + 54'(r_p01) + 54'(r_p02);
        s_sum_z  = 54'(r_p20) + 54'(r_p21) + 54'(r_p22);
        s_fwd    = -(27'(r_lz));
        s_right  = 27'(r_lx);
        s_long_p = $signed({1'b0, i_cfg.long_gain}) * s_fwd;
        s_lat_p  = $signed({1'b0, i_cfg.lat_gain}) * s_right;
        s_st     = $signed({18'b0, i_cfg.static_load});
        s_dl     = 38'(r_dlong);
        s_dt     = 38'(r_dlat);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xx  <= i_quat_x * i_quat_x;
            r_yy  <= i_quat_y * i_quat_y;
            r_zz  <= i_quat_z * i_quat_z;
            r_xy  <= i_quat_x * i_quat_y;
            r_wz  <= i_quat_w * i_quat_z;
            r_xz  <= i_quat_x * i_quat_z;
            r_wy  <= i_quat_w * i_quat_y;
            r_yz  <= i_quat_y * i_quat_z;
            r_wx  <= i_quat_w * i_quat_x;
            r_ax1 <= i_accel_x;
            r_ay1 <= i_accel_y;
            r_az1 <= i_accel_z;

            r_m00 <= ONE_Q28 - (s_yz_sum <<< 1);
            r_m01 <= (34'(r_xy) + 34'(r_wz)) <<< 1;
            r_m02 <= (34'(r_xz) - 34'(r_wy)) <<< 1;
            r_m20 <= (34'(r_xz) + 34'(r_wy)) <<< 1;
            r_m21 <= (34'(r_yz) - 34'(r_wx)) <<< 1;
            r_m22 <= ONE_Q28 - (s_xy_sum <<< 1);
            r_ax2 <= r_ax1;
            r_ay2 <= r_ay1;
            r_az2 <= r_az1;

            r_p00 <= r_m00 * r_ax2;
            r_p01 <= r_m01 * r_ay2;
            r_p02 <= r_m02 * r_az2;
            r_p20 <= r_m20 * r_ax2;
            r_p21 <= r_m21 * r_ay2;
            r_p22 <= r_m22 * r_az2;

            // floor by 2^28 is the upper slice
            r_lx <= s_sum_x[53:28];
            r_lz <= s_sum_z[53:28];

            r_dlong <= s_long_p[47:12];
            r_dlat  <= s_lat_p[47:12];

            r_loads[0] <= clamp_load(s_st - s_dl + s_dt);
            r_loads[1] <= clamp_load(s_st - s_dl - s_dt);
            r_loads[2] <= clamp_load(s_st + s_dl + s_dt);
            r_loads[3] <= clamp_load(s_st + s_dl - s_dt);
        end
    end

endmodule

// ===== rtl/core/wlt_fifo.sv =====
module wlt_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  wlt_pkg::t_corners  i_data,
    input  logic               i_pop,
    output wlt_pkg::t_corners  o_data,
    output wlt_pkg::t_q_status o_status
);
    import wlt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    t_corners          r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == FULL);
    assign o_status.empty = (r_count == '0);

    // store incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full && !i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count out of range");

endmodule

// ===== rtl/core/wlt_back.sv =====
module wlt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wlt_pkg::t_cfg      i_cfg,
    input  wlt_pkg::t_q_status i_q_status,
    input  wlt_pkg::t_corners  i_loads,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output wlt_pkg::t_corners  o_loads,
    output wlt_pkg::t_corners  o_comps
);
    import wlt_pkg::*;

    localparam int QB    = LOAD_W;      // quotient bits kept
    localparam int DIV_W = 36;          // load * 62500
    localparam int CMP_W = DIV_W + 7;

    logic en;

    logic                       r_dv;
    t_corners                   r_dload;
    logic [CORNERS-1:0][DIV_W-1:0] r_dvd;

    // divider stages: index 0 holds the overflow check, then one bit each
    logic [QB:0]                     r_sv;
    t_corners                        r_sload [QB+1];
    logic [CORNERS-1:0][DIV_W-1:0]   r_rem   [QB+1];
    logic [CORNERS-1:0][QB-1:0]      r_q     [QB+1];
    logic [CORNERS-1:0]              r_ovf   [QB+1];

    logic                       r_ov;
    t_corners                   r_oload, r_ocomp;

    logic [CORNERS-1:0][DIV_W-1:0] n_rem [QB+1];
    logic [CORNERS-1:0][QB-1:0]    n_q   [QB+1];
    logic [CORNERS-1:0]            n_ovf [QB+1];
    logic [CMP_W-1:0]              s_div;
    t_corners                      n_comp;

    // advance unless the result word is held by the sink
    assign en      = !(r_ov && i_stall);
    assign o_pop   = en && !i_q_status.empty;
    assign o_valid = r_ov;
    assign o_loads = r_oload;
    assign o_comps = r_ocomp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_sv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= !i_q_status.empty;
            r_sv <= {r_sv[QB-1:0], r_dv};
            r_ov <= r_sv[QB];
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        s_div = '0;
        for (int c = 0; c < CORNERS; c++) begin
            n_ovf[0][c] = {7'b0, r_dvd[c]} >= ({21'b0, i_cfg.spring_rate} << QB);
            n_rem[0][c] = r_dvd[c];
            n_q[0][c]   = '0;
        end
        for (int s = 1; s <= QB; s++) begin
            for (int c = 0; c < CORNERS; c++) begin
                s_div       = {21'b0, i_cfg.spring_rate} << (QB - s);
                n_ovf[s][c] = r_ovf[s-1][c];
                n_q[s][c]   = r_q[s-1][c];
                n_rem[s][c] = r_rem[s-1][c];
                if ({7'b0, r_rem[s-1][c]} >= s_div) begin
                    n_rem[s][c]       = r_rem[s-1][c] - s_div[DIV_W-1:0];
                    n_q[s][c][QB - s] = 1'b1;
                end
            end
        end
        // limit by travel
        for (int c = 0; c < CORNERS; c++) begin
            if (r_ovf[QB][c] || (r_q[QB][c] > i_cfg.max_travel)) begin
                n_comp[c] = i_cfg.max_travel;
            end else begin
                n_comp[c] = r_q[QB][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dload <= i_loads;
            for (int c = 0; c < CORNERS; c++) begin
                r_dvd[c] <= DIV_W'(i_loads[c]) * DIV_W'(COMP_SCALE);
            end
            r_sload[0] <= r_dload;
            r_rem[0]   <= n_rem[0];
            r_q[0]     <= n_q[0];
            r_ovf[0]   <= n_ovf[0];
            for (int s = 1; s <= QB; s++) begin
                r_sload[s] <= r_sload[s-1];
                r_rem[s]   <= n_rem[s];
                r_q[s]     <= n_q[s];
                r_ovf[s]   <= n_ovf[s];
            end
            r_oload <= r_sload[QB];
            r_ocomp <= n_comp;
        end
    end

endmodule

// ===== rtl/core/wheel_load_transfer.sv =====
// The path from an accepted input word to its result word runs through 6 front stages
// for rotation and transfer, the queue and 23 back stages.
// One word per cycle when nothing stalls; the back part runs a 21-stage restoring divider per corner
// (one range check stage, then one quotient bit per stage for 20 bits).
// A 4-entry queue lets the front keep accepting while the output is stalled, until the queue fills.
// Reset (synchronous, active low) empties the pipelines and queue and loads register defaults.
module wheel_load_transfer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wlt_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [wlt_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_w,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_x,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_y,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_z,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_x,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_y,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [wlt_pkg::LOAD_W-1:0]        o_load_fl,
    output logic [wlt_pkg::LOAD_W-1:0]        o_load_fr,
    output logic [wlt_pkg::LOAD_W-1:0]        o_load_rl,
    output logic [wlt_pkg::LOAD_W-1:0]        o_load_rr,
    output logic [wlt_pkg::LOAD_W-1:0]        o_comp_fl,
    output logic [wlt_pkg::LOAD_W-1:0]        o_comp_fr,
    output logic [wlt_pkg::LOAD_W-1:0]        o_comp_rl,
    output logic [wlt_pkg::LOAD_W-1:0]        o_comp_rr
);
    import wlt_pkg::*;

    t_cfg      r_cfg;
    t_q_status s_qs;
    logic      s_push, s_pop;
    t_corners  s_fr_loads, s_q_loads, s_out_loads, s_out_comps;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.static_load <= 20'd31315;
            r_cfg.long_gain   <= 20'd9885;
            r_cfg.lat_gain    <= 20'd20988;
            r_cfg.spring_rate <= 22'd200000;
            r_cfg.max_travel  <= 20'd50000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STATIC_LOAD: r_cfg.static_load <= i_cfg_data[LOAD_W-1:0];
                REG_LONG_GAIN:   r_cfg.long_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_LAT_GAIN:    r_cfg.lat_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_SPRING_RATE: r_cfg.spring_rate <= i_cfg_data[SPRING_W-1:0];
                REG_MAX_TRAVEL:  r_cfg.max_travel  <= i_cfg_data[LOAD_W-1:0];
                default: ;
            endcase
        end
    end

    wlt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_quat_w   (i_quat_w),
        .i_quat_x   (i_quat_x),
        .i_quat_y   (i_quat_y),
        .i_quat_z   (i_quat_z),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_q_status (s_qs),
        .o_push     (s_push),
        .o_loads    (s_fr_loads)
    );

    wlt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_data   (s_fr_loads),
        .i_pop    (s_pop),
        .o_data   (s_q_loads),
        .o_status (s_qs)
    );

    wlt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (s_qs),
        .i_loads    (s_q_loads),
        .o_pop      (s_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_loads    (s_out_loads),
        .o_comps    (s_out_comps)
    );

    assign o_load_fl = s_out_loads[0];
    assign o_load_fr = s_out_loads[1];
    assign o_load_rl = s_out_loads[2];
    assign o_load_rr = s_out_loads[3];
    assign o_comp_fl = s_out_comps[0];
    assign o_comp_fr = s_out_comps[1];
    assign o_comp_rl = s_out_comps[2];
    assign o_comp_rr = s_out_comps[3];

endmodule

// ===== test/wlt_checker.sv =====
`timescale 1ns / 1ps

module wlt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wlt_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [wlt_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_w,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_x,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_y,
    input  logic signed [wlt_pkg::QUAT_W-1:0] i_quat_z,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_x,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_y,
    input  logic signed [wlt_pkg::ACC_W-1:0]  i_accel_z,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  wlt_pkg::t_corners                 i_loads,
    input  wlt_pkg::t_corners                 i_comps,
    output int                                o_fail_count,
    output int                                o_pending
);
    import wlt_pkg::*;

    typedef struct packed {
        t_corners loads;
        t_corners comps;
    } t_corner_word;

    t_cfg         cfg;
    t_corner_word corner_q[$];

    assign o_pending = corner_q.size();

    // floor division by 2^s
    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic t_load clamp_to_load(longint v);
        if (v < 0) return '0;
        if (v > longint'(LOAD_MAX)) return LOAD_MAX;
        return t_load'(v);
    endfunction

    // weight transfer for one pose and acceleration word
    function automatic t_corner_word predict_corners(t_cfg c,
            longint w, longint x, longint y, longint z,
            longint ax, longint ay, longint az);
        longint       one;
        longint       lx;
        longint       lz;
        longint       dlong;
        longint       dlat;
        longint       st;
        longint       raw [4];
        longint       cq;
        t_corner_word r;
        one = longint'(1) << 28;
        lx = (one - 2 * (y * y + z * z)) * ax + 2 * (x * y + w * z) * ay
           + 2 * (x * z - w * y) * az;
        lz = 2 * (x * z + w * y) * ax + 2 * (y * z - w * x) * ay
           + (one - 2 * (x * x + y * y)) * az;
        lx = floor_div_pow2(lx, 28);
        lz = floor_div_pow2(lz, 28);
        dlong = floor_div_pow2(longint'(c.long_gain) * -lz, 12);
        dlat  = floor_div_pow2(longint'(c.lat_gain) * lx, 12);
        st = longint'(c.static_load);
        raw[0] = st - dlong + dlat;
        raw[1] = st - dlong - dlat;
        raw[2] = st + dlong + dlat;
        raw[3] = st + dlong - dlat;
        for (int i = 0; i < 4; i++) begin
            r.loads[i] = clamp_to_load(raw[i]);
            if (c.spring_rate == 0) begin
                cq = longint'(c.max_travel);
            end else begin
                cq = (longint'(r.loads[i]) * 62500) / longint'(c.spring_rate);
                if (cq > longint'(c.max_travel)) cq = longint'(c.max_travel);
            end
            r.comps[i] = t_load'(cq);
        end
        return r;
    endfunction

    // track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        t_corner_word exp_w;
        int           errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg.static_load <= 20'd31315;
            cfg.long_gain   <= 20'd9885;
            cfg.lat_gain    <= 20'd20988;
            cfg.spring_rate <= 22'd200000;
            cfg.max_travel  <= 20'd50000;
            corner_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STATIC_LOAD: cfg.static_load <= i_cfg_data[LOAD_W-1:0];
                    REG_LONG_GAIN:   cfg.long_gain   <= i_cfg_data[GAIN_W-1:0];
                    REG_LAT_GAIN:    cfg.lat_gain    <= i_cfg_data[GAIN_W-1:0];
                    REG_SPRING_RATE: cfg.spring_rate <= i_cfg_data[SPRING_W-1:0];
                    REG_MAX_TRAVEL:  cfg.max_travel  <= i_cfg_data[LOAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                corner_q.push_back(predict_corners(cfg, i_quat_w, i_quat_x, i_quat_y,
                    i_quat_z, i_accel_x, i_accel_y, i_accel_z));
            if (i_out_valid && !i_out_stall) begin
                if (corner_q.size() == 0) begin
                    $display("%0t: unexpected word loads=%h comps=%h", $time,
                             i_loads, i_comps);
                    errs = errs + 1;
                end else begin
                    exp_w = corner_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (exp_w.loads[i] !== i_loads[i]) begin
                            $display("%0t: load[%0d] expected %0d actual %0d", $time, i,
                                     exp_w.loads[i], i_loads[i]);
                            errs = errs + 1;
                        end
                        if (exp_w.comps[i] !== i_comps[i]) begin
                            $display("%0t: comp[%0d] expected %0d actual %0d", $time, i,
                                     exp_w.comps[i], i_comps[i]);
                            errs = errs + 1;
                        end
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ===== test/tb_wheel_load_transfer.sv =====
`timescale 1ns / 1ps

module tb_wheel_load_transfer;
    import wlt_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [IDX_W-1:0]         i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [QUAT_W-1:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic signed [ACC_W-1:0]  i_accel_x, i_accel_y, i_accel_z;
    logic                     o_valid;
    logic                     i_stall;
    t_corners                 loads, comps;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles;
    bit                       sending_done;

    wheel_load_transfer u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_accel_x, .i_accel_y, .i_accel_z,
        .o_valid, .i_stall,
        .o_load_fl(loads[0]), .o_load_fr(loads[1]),
        .o_load_rl(loads[2]), .o_load_rr(loads[3]),
        .o_comp_fl(comps[0]), .o_comp_fr(comps[1]),
        .o_comp_rl(comps[2]), .o_comp_rr(comps[3])
    );

    wlt_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_accel_x, .i_accel_y, .i_accel_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_loads(loads), .i_comps(comps),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // send one word and hold it until accepted; valid stays up for a back-to-back word
    task automatic send_word(int w, int x, int y, int z, int ax, int ay, int az);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_quat_w  <= QUAT_W'(w);
        i_quat_x  <= QUAT_W'(x);
        i_quat_y  <= QUAT_W'(y);
        i_quat_z  <= QUAT_W'(z);
        i_accel_x <= ACC_W'(ax);
        i_accel_y <= ACC_W'(ay);
        i_accel_z <= ACC_W'(az);
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // drop valid and let the pipeline drain before touching registers
    task automatic drain;
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int rand_quat();
        case ($urandom_range(0, 5))
            0: return 16384;
            1: return -16384;
            2: return 0;
            3: return $signed(16'($urandom));
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic int rand_accel();
        case ($urandom_range(0, 5))
            0: return 131071;
            1: return -131072;
            2: return int'($urandom_range(0, 8000)) - 4000;
            default: return $signed(18'($urandom));
        endcase
    endfunction

    // receiver stall pattern
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            i_stall <= (hold != 0);
            if (hold != 0) begin
                repeat (hold) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("wheel_load_transfer regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_quat_w = '0; i_quat_x = '0; i_quat_y = '0; i_quat_z = '0;
        i_accel_x = '0; i_accel_y = '0; i_accel_z = '0;
        idle_cycles = 0; sending_done = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, extremes, non-unit quaternions, reset registers
        send_word(16384, 0, 0, 0, 0, 0, 0);
        send_word(16384, 0, 0, 0, 2000, 0, 0);
        send_word(16384, 0, 0, 0, 0, 0, -2000);
        send_word(16384, 0, 0, 0, -131072, 131071, 131071);
        send_word(-16384, 16384, -16384, 16384, 131071, -131072, -131072);
        send_word(0, 16384, 0, 0, 5000, 5000, 5000);
        send_word(11585, 0, 11585, 0, 3000, -1000, 2500);
        send_word(-32768, 32767, -32768, 32767, 131071, 131071, -131072);
        send_word(16384, 0, 0, 0, -1, -1, -1);
        drain();

        // zero spring, extreme gains and static load
        write_reg(REG_SPRING_RATE, 0);
        write_reg(REG_MAX_TRAVEL, 20'hFFFFF);
        write_reg(REG_STATIC_LOAD, 20'hFFFFF);
        write_reg(REG_LONG_GAIN, 20'hFFFFF);
        write_reg(REG_LAT_GAIN, 20'hFFFFF);
        write_reg(t_reg_idx'(3'd7), 12345);
        send_word(16384, 0, 0, 0, 131071, 0, -131072);
        send_word(16384, 0, 0, 0, -131072, 0, 131071);
        send_word(0, 0, 0, 16384, 100, 100, 100);
        drain();
        write_reg(REG_SPRING_RATE, 1);
        write_reg(REG_STATIC_LOAD, 0);
        write_reg(REG_LONG_GAIN, 0);
        write_reg(REG_LAT_GAIN, 0);
        write_reg(REG_MAX_TRAVEL, 0);
        send_word(16384, 0, 0, 0, 131071, 0, 131071);
        send_word(16384, 0, 0, 0, 1000, 0, 1000);
        drain();
        write_reg(REG_SPRING_RATE, 22'h3FFFFF);
        write_reg(REG_MAX_TRAVEL, 20'hFFFFF);
        write_reg(REG_STATIC_LOAD, 20'hFFFFF);
        send_word(16384, 0, 0, 0, 0, 0, 0);
        drain();

        // random phases with random settings
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_STATIC_LOAD, (phase == 0) ? 31315 : $urandom_range(0, 20'hFFFFF));
            write_reg(REG_LONG_GAIN, (phase % 2) ? $urandom_range(0, 20'hFFFFF)
                                                  : $urandom_range(0, 40000));
            write_reg(REG_LAT_GAIN, (phase % 2) ? $urandom_range(0, 20'hFFFFF)
                                                 : $urandom_range(0, 40000));
            write_reg(REG_SPRING_RATE, (phase == 3) ? 0 : $urandom_range(1, 22'h3FFFFF));
            write_reg(REG_MAX_TRAVEL, $urandom_range(0, 20'hFFFFF));
            for (int n = 0; n < 88; n++) begin
                if (n == 44) begin
                    // hold off until every expected word is out
                    i_valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge i_clk);
                end
                send_word(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                          rand_accel(), rand_accel(), rand_accel());
            end
            drain();
        end

        sending_done = 1'b1;
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("wheel_load_transfer regression: pass");
        end else begin
            $display("wheel_load_transfer regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/wlt_pkg.sv
rtl/core/wlt_front.sv
rtl/core/wlt_fifo.sv
rtl/core/wlt_back.sv
rtl/core/wheel_load_transfer.sv
test/wlt_checker.sv
test/tb_wheel_load_transfer.sv
